>>> rtl/emst_pkg.sv
// Shared constants and control types for the spanning tree length block.
package emst_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 49;
    localparam int ROOT_W     = 25;
    localparam int TOTAL_W    = 35;
    localparam int OCNT_W     = 11;

    // control from the sequencer to the memory datapath
    typedef struct packed {
        logic             wr_pt;
        logic             rd_pick;
        logic             issue;
        logic             first;
        logic             start;
        logic             mark;
        logic [IDX_W-1:0] addr;
    } t_core_ctl;

    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] best_idx;
        logic [SQ_W-1:0]  best_nd;
    } t_core_sts;

endpackage

>>> rtl/emst_sqrt.sv
// Iterative floor square root, one result bit per cycle.
module emst_sqrt
    import emst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_value,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int RW = 2 * ROOT_W + 1;

    logic          r_busy;
    logic          r_done;
    logic [SQ_W-1:0] r_v;
    logic [RW-1:0] r_root;
    logic [RW-1:0] r_bit;
    logic [RW-1:0] w_sum;
    logic          w_ge;

    assign w_sum = r_root + r_bit;
    assign w_ge  = {{(RW - SQ_W){1'b0}}, r_v} >= w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_v    <= i_value;
            r_root <= '0;
            r_bit  <= {1'b1, {(RW - 1){1'b0}}};
        end else if (r_busy) begin
            if (w_ge) begin
                r_v    <= r_v - w_sum[SQ_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[ROOT_W-1:0];

endmodule

>>> rtl/emst_core.sv
// Point and work memories with the distance update and nearest search pipeline.
module emst_core
    import emst_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_core_ctl                 i_ctl,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    output t_core_sts                 o_sts
);

    logic [2*COORD_W-1:0] pt_mem [MAX_POINTS];
    logic [SQ_W:0]        wk_mem [MAX_POINTS];

    logic [2*COORD_W-1:0] r_pt_q;
    logic [SQ_W:0]        r_wk_q;
    logic signed [COORD_W-1:0] r_px, r_py;

    logic r_v1, r_v2, r_v3, r_v4, r_pk1;
    logic [IDX_W-1:0] r_idx1, r_idx2, r_idx3, r_idx4;
    logic [DIFF_W-1:0] r_dx2, r_dy2;
    logic [SQ_W-1:0] r_nd2, r_nd3, r_nd4;
    logic r_jn2, r_jn3, r_jn4;
    logic [SQ_W-1:0] r_sqx3, r_sqy3, r_d4;

    logic            r_found;
    logic [IDX_W-1:0] r_best_idx;
    logic [SQ_W-1:0] r_best_nd;

    logic signed [DIFF_W-1:0] w_ddx, w_ddy;
    logic [2*DIFF_W-1:0] w_mx, w_my;
    logic [SQ_W-1:0] w_nn;
    logic            w_upd;
    logic            w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [SQ_W:0]   w_wdata;

    assign w_ddx = DIFF_W'(r_px) - DIFF_W'($signed(r_pt_q[2*COORD_W-1:COORD_W]));
    assign w_ddy = DIFF_W'(r_py) - DIFF_W'($signed(r_pt_q[COORD_W-1:0]));
    assign w_mx  = r_dx2 * r_dx2;
    assign w_my  = r_dy2 * r_dy2;

    assign w_nn  = (i_ctl.first || r_d4 < r_nd4) ? r_d4 : r_nd4;
    assign w_upd = r_v4 && !r_jn4;

    always_comb begin
        if (i_ctl.mark) begin
            w_we    = 1'b1;
            w_waddr = i_ctl.addr;
            w_wdata = {{SQ_W{1'b0}}, 1'b1};
        end else begin
            w_we    = w_upd;
            w_waddr = r_idx4;
            w_wdata = {w_nn, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_pt) begin
            pt_mem[i_ctl.addr] <= {i_x, i_y};
        end
        r_pt_q <= pt_mem[i_ctl.addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            wk_mem[w_waddr] <= w_wdata;
        end
        r_wk_q <= wk_mem[i_ctl.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_pk1   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_v1  <= i_ctl.issue;
            r_pk1 <= i_ctl.rd_pick;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            if (i_ctl.start) begin
                r_found <= 1'b0;
            end else if (w_upd && (!r_found || w_nn < r_best_nd)) begin
                r_found <= 1'b1;
            end
        end
        if (w_upd && (!r_found || w_nn < r_best_nd) && !i_ctl.start) begin
            r_best_idx <= r_idx4;
            r_best_nd  <= w_nn;
        end
        if (r_pk1) begin
            r_px <= $signed(r_pt_q[2*COORD_W-1:COORD_W]);
            r_py <= $signed(r_pt_q[COORD_W-1:0]);
        end
        r_idx1 <= i_ctl.addr;
        // stage 2: absolute differences
        r_idx2 <= r_idx1;
        r_dx2  <= w_ddx[DIFF_W-1] ? DIFF_W'(-w_ddx) : DIFF_W'(w_ddx);
        r_dy2  <= w_ddy[DIFF_W-1] ? DIFF_W'(-w_ddy) : DIFF_W'(w_ddy);
        r_nd2  <= r_wk_q[SQ_W:1];
        r_jn2  <= i_ctl.first ? 1'b0 : r_wk_q[0];
        // stage 3: squares
        r_idx3 <= r_idx2;
        r_sqx3 <= w_mx[SQ_W-1:0];
        r_sqy3 <= w_my[SQ_W-1:0];
        r_nd3  <= r_nd2;
        r_jn3  <= r_jn2;
        // stage 4: squared distance, fits its width without wrapping
        r_idx4 <= r_idx3;
        r_d4   <= r_sqx3 + r_sqy3;
        r_nd4  <= r_nd3;
        r_jn4  <= r_jn3;
    end

    assign o_sts.busy     = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_sts.best_idx = r_best_idx;
    assign o_sts.best_nd  = r_best_nd;

endmodule

>>> rtl/euclidean_mst_total_length.sv
// After the last point, the set closes in N-1 Prim rounds for N stored points;
// points load one per cycle while the block is in S_LOAD. The pace of a round is set by the
// single read port of the work memory, visited once per point but the first in each Prim round.
// The result register lets the next set load while a result waits.
// Reset is synchronous, active low; memories are not cleared.
module euclidean_mst_total_length
    import emst_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic                      i_last_point,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [TOTAL_W-1:0]        o_total_length,
    output logic [OCNT_W-1:0]         o_point_count,
    output logic                      o_overflowed
);

    typedef enum logic [2:0] {
        S_LOAD, S_PICK_RD, S_PICK_WT, S_PASS, S_DRAIN, S_SQRT_GO, S_SQRT_WT, S_FINISH
    } t_state;

    t_state r_state;
    logic [CNT_W-1:0]   r_cnt, r_n, r_round;
    logic               r_drop;
    logic [IDX_W-1:0]   r_pick, r_i;
    logic [TOTAL_W-1:0] r_total;

    t_core_ctl        w_ctl;
    t_core_sts        w_sts;
    logic             w_acc;
    logic             w_room;
    logic [CNT_W-1:0] w_cnt_nx;
    logic             w_sq_done;
    logic [ROOT_W-1:0] w_root;
    logic [TOTAL_W:0] w_sum;
    logic             w_out_free;

    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_room     = r_cnt < CNT_W'(MAX_POINTS);
    assign w_cnt_nx   = w_room ? r_cnt + 1'b1 : r_cnt;
    assign w_sum      = {1'b0, r_total} + (TOTAL_W + 1)'(w_root);
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_LOAD);

    always_comb begin
        w_ctl         = '0;
        w_ctl.first   = (r_round == CNT_W'(1));
        unique case (r_state)
            S_LOAD: begin
                w_ctl.addr  = r_cnt[IDX_W-1:0];
                w_ctl.wr_pt = w_acc && w_room;
            end
            S_PICK_RD: begin
                w_ctl.addr    = r_pick;
                w_ctl.rd_pick = 1'b1;
            end
            S_PICK_WT: begin
                w_ctl.addr  = r_pick;
                w_ctl.start = 1'b1;
            end
            S_PASS: begin
                w_ctl.addr  = r_i;
                w_ctl.issue = 1'b1;
            end
            S_SQRT_GO: begin
                w_ctl.addr = w_sts.best_idx;
                w_ctl.mark = 1'b1;
            end
            default: begin
                w_ctl.addr = r_pick;
            end
        endcase
    end

    emst_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .o_sts   (w_sts)
    );

    emst_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQRT_GO),
        .i_value (w_sts.best_nd),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // S_FINISH owns the valid flag while it is active
            if (o_out_valid && !i_out_stall && r_state != S_FINISH) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        r_cnt <= w_cnt_nx;
                        if (!w_room) begin
                            r_drop <= 1'b1;
                        end
                        if (i_last_point) begin
                            r_n     <= w_cnt_nx;
                            r_total <= '0;
                            r_round <= CNT_W'(1);
                            r_pick  <= '0;
                            r_state <= (w_cnt_nx < CNT_W'(2)) ? S_FINISH : S_PICK_RD;
                        end
                    end
                end
                S_PICK_RD: r_state <= S_PICK_WT;
                S_PICK_WT: begin
                    r_i     <= IDX_W'(1);
                    r_state <= S_PASS;
                end
                S_PASS: begin
                    if (r_i == IDX_W'(r_n - 1'b1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!w_sts.busy) begin
                        r_state <= S_SQRT_GO;
                    end
                end
                S_SQRT_GO: r_state <= S_SQRT_WT;
                S_SQRT_WT: begin
                    if (w_sq_done) begin
                        r_total <= w_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : w_sum[TOTAL_W-1:0];
                        if (r_round == r_n - 1'b1) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_round <= r_round + 1'b1;
                            r_pick  <= w_sts.best_idx;
                            r_state <= S_PICK_RD;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        o_out_valid    <= 1'b1;
                        o_total_length <= r_total;
                        o_point_count  <= r_n[OCNT_W-1:0];
                        o_overflowed   <= r_drop;
                        r_cnt          <= '0;
                        r_drop         <= 1'b0;
                        r_state        <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

>>> sim/emst_checker.sv
// Channel monitor and spanning tree length predictor for euclidean_mst_total_length.
`timescale 1ns / 100ps
module emst_checker
    import emst_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic                      i_last_point,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [TOTAL_W-1:0]        i_total_length,
    input  logic [OCNT_W-1:0]         i_point_count,
    input  logic                      i_overflowed,
    output int                        o_errors,
    output int                        o_pending
);

    typedef struct {
        logic [TOTAL_W-1:0] total;
        logic [OCNT_W-1:0]  count;
        logic               ovf;
    } t_tree_result;

    localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

    logic signed [COORD_W-1:0] set_x [MAX_POINTS];
    logic signed [COORD_W-1:0] set_y [MAX_POINTS];
    int                        set_n;
    logic                      set_dropped;
    t_tree_result              expected_trees [$];

    function automatic longint unsigned sq_dist(int a, int b);
        longint signed dx;
        longint signed dy;
        dx = longint'(set_x[a]) - longint'(set_x[b]);
        dy = longint'(set_y[a]) - longint'(set_y[b]);
        return longint'(dx * dx + dy * dy);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 24; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Prim over exact squared distances
    function automatic longint unsigned span_length(int n);
        longint unsigned best [MAX_POINTS];
        bit              joined [MAX_POINTS];
        longint unsigned sum;
        longint unsigned d;
        int              pick;
        sum = 0;
        if (n < 2) return 0;
        for (int i = 1; i < n; i++) begin
            joined[i] = 0;
            best[i]   = sq_dist(0, i);
        end
        for (int r = 1; r < n; r++) begin
            pick = -1;
            for (int i = 1; i < n; i++)
                if (!joined[i] && (pick < 0 || best[i] < best[pick])) pick = i;
            joined[pick] = 1;
            sum += int_sqrt(best[pick]);
            if (sum > TOTAL_SAT) sum = 64'(TOTAL_SAT);
            for (int i = 1; i < n; i++) begin
                if (!joined[i]) begin
                    d = sq_dist(pick, i);
                    if (d < best[i]) best[i] = d;
                end
            end
        end
        return sum;
    endfunction

    always @(posedge i_clk) begin
        t_tree_result e;
        if (!i_rst_n) begin
            set_n       = 0;
            set_dropped = 0;
            o_errors    = 0;
            o_pending   = 0;
            expected_trees.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (set_n < MAX_POINTS) begin
                    set_x[set_n] = i_point_x;
                    set_y[set_n] = i_point_y;
                    set_n++;
                end else begin
                    set_dropped = 1;
                end
                if (i_last_point) begin
                    e.total = TOTAL_W'(span_length(set_n));
                    e.count = set_n[OCNT_W-1:0];
                    e.ovf   = set_dropped;
                    expected_trees.push_back(e);
                    set_n       = 0;
                    set_dropped = 0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_trees.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result: total=%0d count=%0d ovf=%0d",
                                 i_total_length, i_point_count, i_overflowed);
                end else begin
                    e = expected_trees.pop_front();
                    if (e.total !== i_total_length || e.count !== i_point_count ||
                        e.ovf !== i_overflowed) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("bad result: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     e.total, e.count, e.ovf, i_total_length,
                                     i_point_count, i_overflowed);
                    end
                end
            end
            o_pending = expected_trees.size();
        end
    end

endmodule

>>> sim/tb_top.sv
// Stimulus, clock, watchdog and verdict for euclidean_mst_total_length.
`timescale 1ns / 100ps
module tb_top;
    import emst_pkg::*;

    localparam int STALL_LIMIT = 3000000;

    logic                      i_clk = 0;
    logic                      i_rst_n = 0;
    logic                      i_in_valid = 0;
    logic signed [COORD_W-1:0] i_point_x = '0;
    logic signed [COORD_W-1:0] i_point_y = '0;
    logic                      i_last_point = 0;
    logic                      i_out_stall = 0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic [TOTAL_W-1:0]        o_total_length;
    logic [OCNT_W-1:0]         o_point_count;
    logic                      o_overflowed;
    int                        errors;
    int                        pending;
    int                        idle_cycles = 0;
    int                        out_hold = 0;
    bit                        no_gaps = 0;
    bit                        took_result = 0;

    always #1 i_clk = ~i_clk;

    euclidean_mst_total_length dut (.*);

    emst_checker u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_point_x,
        .i_point_y, .i_last_point, .i_out_valid(o_out_valid), .i_out_stall,
        .i_total_length(o_total_length), .i_point_count(o_point_count),
        .i_overflowed(o_overflowed), .o_errors(errors), .o_pending(pending)
    );

    // receiver backpressure
    always @(posedge i_clk) took_result <= o_out_valid && !i_out_stall;
    always @(negedge i_clk) begin
        if (took_result) out_hold = no_gaps ? 0 : $urandom_range(0, 3);
        i_out_stall <= (out_hold != 0);
        if (out_hold > 0) out_hold--;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("euclidean_mst_total_length: mismatch");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1;
        i_point_x    <= x;
        i_point_y    <= y;
        i_last_point <= last;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(bit wide);
        if (wide) return COORD_W'($urandom);
        return COORD_W'($signed(COORD_W'($urandom_range(0, 4095))) - 2048);
    endfunction

    task automatic send_random_set(int n);
        bit wide;
        wide = $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(wide), rand_coord(wide), i == n - 1);
    endtask

    localparam logic signed [COORD_W-1:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] CMIN = 24'sh800000;

    initial begin
        int n;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // single point gives zero
        send_point(CMAX, CMIN, 1);
        send_point(0, 0, 1);
        // extreme separation on both axes
        send_point(CMIN, CMIN, 0);
        send_point(CMAX, CMAX, 1);
        send_point(CMAX, CMIN, 0);
        send_point(CMIN, CMAX, 1);
        // equal distances: square corners plus center
        send_point(0, 0, 0);
        send_point(256, 0, 0);
        send_point(0, 256, 0);
        send_point(256, 256, 0);
        send_point(128, 128, 1);
        // collinear with ties and duplicates, plus one point off the line
        send_point(-512, 3, 0);
        send_point(0, 3, 0);
        send_point(512, 3, 0);
        send_point(512, 3, 0);
        send_point(-1, -1, 1);

        for (int phase = 0; phase < 4; phase++) begin
            no_gaps = (phase == 2);
            for (int k = 0; k < 30; k++) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                : $urandom_range(1, 6);
                send_random_set(n);
            end
            // sender holds off until the block has drained
            i_in_valid <= 0;
            while (pending != 0) @(negedge i_clk);
        end
        no_gaps = 0;

        send_random_set(3);

        i_in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0)
            $display("euclidean_mst_total_length: match");
        else
            $display("euclidean_mst_total_length: mismatch");
        $finish;
    end

endmodule
